// ----- rtl/core/mfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mfr_pkg
// Types and codes shared by the modem frame receiver files.
// ----------------------------------------------------------------------------
package mfr_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef logic [3:0] t_kind;

    localparam logic [7:0] START_BYTE   = 8'hE0;
    localparam logic [7:0] MIN_LENGTH   = 8'd3;
    localparam logic [7:0] FIRST_OFFSET = 8'd2;
    localparam logic [8:0] LIMIT_RESET  = 9'd200;

    localparam logic [7:0] TYPE_STATUS  = 8'h01;
    localparam logic [7:0] TYPE_VERSION = 8'h00;
    localparam logic [7:0] TYPE_HEADER  = 8'h10;
    localparam logic [7:0] TYPE_DATA    = 8'h11;
    localparam logic [7:0] TYPE_EOT     = 8'h13;
    localparam logic [7:0] TYPE_LOST    = 8'h12;
    localparam logic [7:0] TYPE_ACK     = 8'h70;
    localparam logic [7:0] TYPE_NAK     = 8'h7F;
    localparam logic [7:0] TYPE_DUMP    = 8'hF0;
    localparam logic [7:0] TYPE_DEBUG1  = 8'hF1;
    localparam logic [7:0] TYPE_DEBUG5  = 8'hF5;

    localparam t_kind KIND_STATUS  = 4'd0;
    localparam t_kind KIND_VERSION = 4'd1;
    localparam t_kind KIND_HEADER  = 4'd2;
    localparam t_kind KIND_DATA    = 4'd3;
    localparam t_kind KIND_EOT     = 4'd4;
    localparam t_kind KIND_LOST    = 4'd5;
    localparam t_kind KIND_ACK     = 4'd6;
    localparam t_kind KIND_NAK     = 4'd7;
    localparam t_kind KIND_DUMP    = 4'd8;
    localparam t_kind KIND_DEBUG1  = 4'd9;
    localparam t_kind KIND_UNKNOWN = 4'd14;

endpackage

// ----- rtl/core/mfr_kind_decode.sv -----
// ----------------------------------------------------------------------------
// mfr_kind_decode
// Maps the frame type byte onto the frame kind code.
// ----------------------------------------------------------------------------
module mfr_kind_decode (
    input  logic [7:0]    i_type,
    output mfr_pkg::t_kind o_kind
);
    import mfr_pkg::*;

    always_comb begin
        case (i_type) inside
            TYPE_STATUS:  o_kind = KIND_STATUS;
            TYPE_VERSION: o_kind = KIND_VERSION;
            TYPE_HEADER:  o_kind = KIND_HEADER;
            TYPE_DATA:    o_kind = KIND_DATA;
            TYPE_EOT:     o_kind = KIND_EOT;
            TYPE_LOST:    o_kind = KIND_LOST;
            TYPE_ACK:     o_kind = KIND_ACK;
            TYPE_NAK:     o_kind = KIND_NAK;
            TYPE_DUMP:    o_kind = KIND_DUMP;
            [TYPE_DEBUG1:TYPE_DEBUG5]:
                o_kind = KIND_DEBUG1 + t_kind'(i_type[3:0] - TYPE_DEBUG1[3:0]);
            default:      o_kind = KIND_UNKNOWN;
        endcase
    end

endmodule

// ----- rtl/core/modem_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// modem_frame_receiver_core
// Length-prefixed serial frame parser: hunts for the start byte, checks the
// length byte and emits every body byte tagged with index, length and kind, or a length error result for a bad length.
// latency: results are registered and appear on the master side in the cycle after their byte is accepted
// throughput: one byte per cycle while the master side is not stalled, set by the state update
// the output register frees while a held result is taken, so no bubble
// reset: synchronous active low, hunting, limit 200, output empty
// ----------------------------------------------------------------------------
module modem_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: length_limit
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // byte_value, byte_index, frame_length
    output logic        o_m_tlast,   // last_of_frame
    output logic [4:0]  o_m_tuser    // frame_kind, length_error
);
    import mfr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_exp_len, n_exp_len;
    logic [7:0]  r_offset, n_offset;
    t_kind       r_kind, n_kind;
    logic [8:0]  r_limit;

    logic        r_m_valid;
    logic [7:0]  r_m_value, r_m_index, r_m_length;
    t_kind       r_m_kind;
    logic        r_m_last, r_m_err;

    logic        accept;
    logic        emit;
    logic [7:0]  res_value, res_index, res_length;
    t_kind       res_kind;
    logic        res_last, res_err;
    t_kind       dec_kind;
    logic        len_bad;
    logic        body_last;

    mfr_kind_decode u_kind (
        .i_type (i_s_tdata),
        .o_kind (dec_kind)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_m_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;

    assign len_bad   = (i_s_tdata < MIN_LENGTH) || ({1'b0, i_s_tdata} >= r_limit);
    assign body_last = ({1'b0, r_offset} + 9'd1) >= {1'b0, r_exp_len};

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_exp_len = r_exp_len;
        n_offset  = r_offset;
        n_kind    = r_kind;
        if (accept) begin
            case (r_phase)
                PH_LEN: begin
                    if (len_bad) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_phase   = PH_BODY;
                        n_exp_len = i_s_tdata;
                        n_offset  = FIRST_OFFSET;
                    end
                end
                PH_BODY: begin
                    if (r_offset == FIRST_OFFSET) begin
                        n_kind = dec_kind;
                    end
                    if (body_last) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_offset = r_offset + 8'd1;
                    end
                end
                default: begin
                    n_phase = (i_s_tdata == START_BYTE) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    // result fields
    always_comb begin
        emit       = 1'b0;
        res_value  = i_s_tdata;
        res_index  = r_offset;
        res_length = r_exp_len;
        res_kind   = (r_offset == FIRST_OFFSET) ? dec_kind : r_kind;
        res_last   = body_last;
        res_err    = 1'b0;
        case (r_phase)
            PH_LEN: begin
                emit       = len_bad;
                res_value  = 8'd0;
                res_index  = 8'd1;
                res_length = i_s_tdata;
                res_kind   = KIND_UNKNOWN;
                res_last   = 1'b0;
                res_err    = 1'b1;
            end
            PH_BODY: begin
                emit = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_exp_len <= 8'd0;
            r_offset  <= 8'd0;
            r_kind    <= KIND_UNKNOWN;
            r_limit   <= LIMIT_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_offset  <= n_offset;
            r_kind    <= n_kind;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_m_valid <= accept && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_m_value  <= res_value;
            r_m_index  <= res_index;
            r_m_length <= res_length;
            r_m_kind   <= res_kind;
            r_m_last   <= res_last;
            r_m_err    <= res_err;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_length, r_m_index, r_m_value};
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = {r_m_err, r_m_kind};

endmodule

// ----- rtl/core/mfr_checker.sv -----
// ----------------------------------------------------------------------------
// mfr_checker
// Port-level checks on the modem frame receiver core, bound into the core module.
// ----------------------------------------------------------------------------
module mfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic [4:0]  o_m_tuser
);
    import mfr_pkg::*;

    // stalled request stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // stalled request keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("result payload changed while stalled");

    // length error carries the fixed marker fields
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[4] |->
            !o_m_tlast && o_m_tdata[7:0] == 8'd0 && o_m_tdata[15:8] == 8'd1
            && o_m_tuser[3:0] == KIND_UNKNOWN)
        else $error("malformed length error result");

    // body byte index lies inside the frame
    a_body_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[4] |->
            o_m_tdata[15:8] >= FIRST_OFFSET && o_m_tdata[15:8] < o_m_tdata[23:16])
        else $error("body byte index outside frame");

    // last flag marks the final position of the frame
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[4] && o_m_tlast |->
            ({1'b0, o_m_tdata[15:8]} + 9'd1) == {1'b0, o_m_tdata[23:16]})
        else $error("last flag on wrong byte");

endmodule

bind modem_frame_receiver_core mfr_checker u_mfr_checker (.*);

// ----- tb/modem_frame_checker.sv -----
// ----------------------------------------------------------------------------
// modem_frame_checker
// Watches the configuration, slave and master channels of the frame receiver,
// tracks the parser state for every accepted byte, and compares each accepted
// result field by field with the oldest predicted frame byte.
// ----------------------------------------------------------------------------
module modem_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // byte_value, byte_index, frame_length
    input  logic        i_m_tlast,   // last_of_frame
    input  logic [4:0]  i_m_tuser,   // frame_kind, length_error
    output int          o_fail_count,
    output int          o_pending
);
    import mfr_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] index;
        logic [7:0] length;
        t_kind      kind;
        logic       last;
        logic       len_err;
    } t_frame_byte;

    t_frame_byte expected_bytes [$];
    t_phase      parse_phase;
    logic [7:0]  body_length;
    logic [7:0]  body_offset;
    t_kind       body_kind;
    logic [8:0]  length_limit;
    int          mismatch_count = 0;

    always @(posedge i_clk) begin : monitor
        t_frame_byte seen;
        t_frame_byte want;
        logic        have;
        logic        last;
        if (!i_rst_n) begin
            parse_phase  = PH_HUNT;
            body_length  = '0;
            body_offset  = '0;
            body_kind    = KIND_UNKNOWN;
            length_limit = LIMIT_RESET;
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                length_limit = i_cfg_data;
            end

            if (i_m_tvalid && i_m_tready) begin
                seen = '{i_m_tdata[7:0], i_m_tdata[15:8], i_m_tdata[23:16],
                         i_m_tuser[3:0], i_m_tlast, i_m_tuser[4]};
                have = (expected_bytes.size() != 0);
                want = '0;
                if (have) begin
                    want = expected_bytes.pop_front();
                end
                if (!have || seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        if (have) begin
                            $display("mismatch: expected v %02h i %0d len %0d kind %0d",
                                     want.value, want.index, want.length, want.kind);
                            $display("          expected last %b err %b",
                                     want.last, want.len_err);
                            $display("          got      v %02h i %0d len %0d kind %0d",
                                     seen.value, seen.index, seen.length, seen.kind);
                            $display("          got      last %b err %b",
                                     seen.last, seen.len_err);
                        end else begin
                            $display("mismatch: result with nothing expected, tdata %06h",
                                     i_m_tdata);
                            $display("          last %b tuser %02h",
                                     i_m_tlast, i_m_tuser);
                        end
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                case (parse_phase)
                    PH_LEN: begin
                        if (i_s_tdata < MIN_LENGTH
                                || {1'b0, i_s_tdata} >= length_limit) begin
                            expected_bytes.push_back('{8'h00, 8'd1, i_s_tdata,
                                                       KIND_UNKNOWN, 1'b0, 1'b1});
                            parse_phase = PH_HUNT;
                        end else begin
                            body_length = i_s_tdata;
                            body_offset = FIRST_OFFSET;
                            parse_phase = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        // type byte selects the kind for the whole frame
                        if (body_offset == FIRST_OFFSET) begin
                            case (i_s_tdata)
                                TYPE_STATUS:  body_kind = KIND_STATUS;
                                TYPE_VERSION: body_kind = KIND_VERSION;
                                TYPE_HEADER:  body_kind = KIND_HEADER;
                                TYPE_DATA:    body_kind = KIND_DATA;
                                TYPE_EOT:     body_kind = KIND_EOT;
                                TYPE_LOST:    body_kind = KIND_LOST;
                                TYPE_ACK:     body_kind = KIND_ACK;
                                TYPE_NAK:     body_kind = KIND_NAK;
                                TYPE_DUMP:    body_kind = KIND_DUMP;
                                default: begin
                                    if (i_s_tdata >= TYPE_DEBUG1
                                            && i_s_tdata <= TYPE_DEBUG5) begin
                                        body_kind = KIND_DEBUG1
                                                  + t_kind'(i_s_tdata - TYPE_DEBUG1);
                                    end else begin
                                        body_kind = KIND_UNKNOWN;
                                    end
                                end
                            endcase
                        end
                        last = ({1'b0, body_offset} + 9'd1 >= {1'b0, body_length});
                        expected_bytes.push_back('{i_s_tdata, body_offset, body_length,
                                                   body_kind, last, 1'b0});
                        if (last) begin
                            parse_phase = PH_HUNT;
                        end else begin
                            body_offset = body_offset + 8'd1;
                        end
                    end
                    default: begin
                        parse_phase = (i_s_tdata == START_BYTE) ? PH_LEN : PH_HUNT;
                    end
                endcase
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= mismatch_count;
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the frame receiver with a short directed byte sequence and then with
// random frames, broken frames and line noise under several length limits,
// with random gaps and stalls on both streams; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import mfr_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_BYTES = 140;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;
    logic [4:0]  o_m_tuser;

    int          fail_count;
    int          pending;
    logic        calm         = 1'b0;
    int          stall_cycles = 0;
    int          bytes_sent   = 0;
    logic [8:0]  limit_now    = LIMIT_RESET;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    modem_frame_receiver_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    modem_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        while (!calm && $urandom_range(99) < 8) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int         len_hi;
        int         frame_len;
        int         pick;
        logic [7:0] type_byte;
        send_byte(START_BYTE);
        len_hi = (limit_now > 9'd255) ? 255 : int'(limit_now) - 1;
        pick = $urandom_range(99);
        if (pick < 10 || (pick < 20 && limit_now > 9'd255)) begin
            frame_len = $urandom_range(2, 0);
        end else if (pick < 20) begin
            frame_len = $urandom_range(255, int'(limit_now));
        end else if (pick < 24) begin
            frame_len = $urandom_range(len_hi, 3);
        end else begin
            frame_len = $urandom_range((len_hi < 12) ? len_hi : 12, 3);
        end
        send_byte(frame_len[7:0]);
        if (frame_len < 3 || frame_len >= int'(limit_now)) return;
        case ($urandom_range(11))
            0:       type_byte = TYPE_STATUS;
            1:       type_byte = TYPE_VERSION;
            2:       type_byte = TYPE_HEADER;
            3:       type_byte = TYPE_DATA;
            4:       type_byte = TYPE_EOT;
            5:       type_byte = TYPE_LOST;
            6:       type_byte = TYPE_ACK;
            7:       type_byte = TYPE_NAK;
            8:       type_byte = TYPE_DUMP;
            9, 10:   type_byte = TYPE_DEBUG1 + 8'($urandom_range(4));
            default: type_byte = 8'($urandom_range(255));
        endcase
        send_byte(type_byte);
        for (int i = 3; i < frame_len; i++) begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic write_limit(input logic [8:0] value);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        limit_now = value;
    endtask

    initial begin
        logic [7:0] opening_bytes [$];
        logic [8:0] next_limit;
        int         target;
        opening_bytes = {8'h55, 8'hFF,
                         START_BYTE, 8'd2,
                         START_BYTE, LIMIT_RESET[7:0],
                         START_BYTE, MIN_LENGTH, TYPE_STATUS,
                         START_BYTE, 8'd4, TYPE_DEBUG5, 8'hFF,
                         START_BYTE, START_BYTE,
                         START_BYTE, 8'd5, 8'h33, 8'h00, 8'hFF,
                         START_BYTE, MIN_LENGTH, START_BYTE};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_bytes[i]) begin
            send_byte(opening_bytes[i]);
        end

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       next_limit = 9'd256;
                1:       next_limit = 9'd4;
                2:       next_limit = 9'($urandom_range(256, 4));
                3:       next_limit = 9'd255;
                default: next_limit = LIMIT_RESET;
            endcase
            write_limit(next_limit);
            calm   <= (p == 2);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                if ($urandom_range(99) < 15) begin
                    // line noise, sometimes a start byte followed by junk
                    if ($urandom_range(3) == 0) begin
                        send_byte(START_BYTE);
                    end
                    repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
                end else begin
                    send_frame();
                end
            end
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
